// ===== src/dmc_pkg.sv =====
// shared widths and constants of the direct-mapped cache lookup
`timescale 1ns / 1ps
`default_nettype none

package dmc_pkg;

  localparam int AddrWidth    = 16;
  localparam int DataWidth    = 31;
  localparam int IdxOutWidth  = 8;
  localparam int CfgWidth     = 9;
  localparam int DefLines     = 256;
  localparam int MaxUsedLines = 256;
  localparam int CntWidth     = $clog2(AddrWidth);

  localparam logic [CfgWidth-1:0] CfgReset = CfgWidth'(256);

endpackage

`default_nettype wire

// ===== src/dmc_req_if.sv =====
// request channel of the cache lookup: address and backing memory word
`timescale 1ns / 1ps
`default_nettype none

interface dmc_req_if
  import dmc_pkg::*;
  ;
  logic                 valid;
  logic                 ready;
  logic [AddrWidth-1:0] address;
  logic [DataWidth-1:0] memory_word;

  modport source (output valid, output address, output memory_word, input ready);
  modport sink   (input valid, input address, input memory_word, output ready);
endinterface

`default_nettype wire

// ===== src/dmc_rsp_if.sv =====
// response channel of the cache lookup: hit, eviction, line and data
`timescale 1ns / 1ps
`default_nettype none

interface dmc_rsp_if
  import dmc_pkg::*;
  ;
  logic                   valid;
  logic                   ready;
  logic                   hit;
  logic                   evicted;
  logic [IdxOutWidth-1:0] line_index;
  logic [DataWidth-1:0]   read_data;

  modport source (output valid, output hit, output evicted, output line_index,
                  output read_data, input ready);
  modport sink   (input valid, input hit, input evicted, input line_index,
                  input read_data, output ready);
endinterface

`default_nettype wire

// ===== src/direct_mapped_cache_lookup.sv =====
// direct-mapped cache lookup with serial modulo line selection
//
// channel  | dir | handshake     | payload
// req_i    | in  | valid / ready | address, memory_word
// rsp_o    | out | valid / ready | hit, evicted, line_index, read_data
// cfg      | in  | cfg_we_i      | cfg_wdata_i (lines in use)
//
// a request passes the accept step, 16 steps of the shift-subtract
// remainder unit (one address bit a cycle), the line read, and compare and fill.
// the response register lets the next request be accepted while a response waits;
// the compare step holds while the response register is full and not being taken.
// reset clears all line valid bits at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module direct_mapped_cache_lookup
  import dmc_pkg::*;
#(
  parameter int LINES = DefLines
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgWidth-1:0] cfg_wdata_i,
  dmc_req_if.sink                  req_i,
  dmc_rsp_if.source                rsp_o
);

  localparam int Depth = (LINES < MaxUsedLines) ? LINES : MaxUsedLines;
  localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [CfgWidth-1:0] DepthCfg = CfgWidth'(Depth);
  localparam logic [CntWidth-1:0] LastStep = CntWidth'(AddrWidth - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_CMP
  } state_e;

  state_e                 state_q;
  logic [CfgWidth-1:0]    cfg_q;
  logic [CfgWidth-1:0]    eff_q;
  logic [CfgWidth-1:0]    eff_d;
  logic [CfgWidth-1:0]    rem_q;
  logic [CfgWidth-1:0]    rem_d;
  logic [CfgWidth:0]      shifted;
  logic [AddrWidth-1:0]   shift_q;
  logic [CntWidth-1:0]    cnt_q;
  logic [AddrWidth-1:0]   addr_q;
  logic [DataWidth-1:0]   word_q;
  logic [Depth-1:0]       valid_q;
  logic                   vld_rd_q;
  logic [AddrWidth+DataWidth-1:0] mem_q [Depth];
  logic [AddrWidth+DataWidth-1:0] rd_q;
  logic [IdxW-1:0]        idx;
  logic                   hit;
  logic                   proceed;
  logic                   out_valid_q;
  logic                   out_hit_q;
  logic                   out_evicted_q;
  logic [IdxOutWidth-1:0] out_idx_q;
  logic [DataWidth-1:0]   out_data_q;

  always_comb begin
    priority if (cfg_q == '0) begin
      eff_d = CfgWidth'(1);
    end else if (cfg_q > DepthCfg) begin
      eff_d = DepthCfg;
    end else begin
      eff_d = cfg_q;
    end
  end

  // one restoring step of address modulo lines in use
  assign shifted = {rem_q, shift_q[AddrWidth-1]};
  assign rem_d   = (shifted >= {1'b0, eff_q}) ? CfgWidth'(shifted - {1'b0, eff_q})
                                              : shifted[CfgWidth-1:0];

  assign idx     = rem_q[IdxW-1:0];
  assign hit     = vld_rd_q && (rd_q[AddrWidth+DataWidth-1:DataWidth] == addr_q);
  assign proceed = (state_q == ST_CMP) && (!out_valid_q || rsp_o.ready);

  assign req_i.ready      = (state_q == ST_IDLE);
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.hit        = out_hit_q;
  assign rsp_o.evicted    = out_evicted_q;
  assign rsp_o.line_index = out_idx_q;
  assign rsp_o.read_data  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= CfgReset;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (out_valid_q && rsp_o.ready && !proceed) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (req_i.valid) begin
            addr_q  <= req_i.address;
            word_q  <= req_i.memory_word;
            shift_q <= req_i.address;
            rem_q   <= '0;
            cnt_q   <= '0;
            eff_q   <= eff_d;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_q   <= rem_d;
          shift_q <= shift_q << 1;
          cnt_q   <= cnt_q + CntWidth'(1);
          if (cnt_q == LastStep) begin
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          vld_rd_q <= valid_q[idx];
          state_q  <= ST_CMP;
        end
        ST_CMP: begin
          if (proceed) begin
            out_valid_q   <= 1'b1;
            out_hit_q     <= hit;
            out_evicted_q <= !hit && vld_rd_q;
            out_idx_q     <= IdxOutWidth'(idx);
            out_data_q    <= hit ? rd_q[DataWidth-1:0] : word_q;
            if (!hit) begin
              valid_q[idx] <= 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // line store: tag and data, read in the read step, filled on a miss
  always_ff @(posedge clk_i) begin
    if (proceed && !hit) begin
      mem_q[idx] <= {addr_q, word_q};
    end
    if (state_q == ST_READ) begin
      rd_q <= mem_q[idx];
    end
  end

`ifndef SYNTHESIS
  a_hit_not_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.hit && rsp_o.evicted))
    else $error("hit and eviction flagged together");

  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (CfgWidth'(rsp_o.line_index) < eff_q))
    else $error("line index not below lines in use");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while lookup busy");

  a_fill_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proceed && !hit) |=> valid_q[$past(idx)])
    else $error("filled line not marked valid");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// testbench of the direct-mapped cache lookup: directed and random requests
`timescale 1ns / 1ps
module tb;
  import dmc_pkg::*;

  localparam int LineCount = 256;
  localparam int MaxGap = 19;
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned PrintLimit = 40;

  typedef struct packed {
    logic                   hit;
    logic                   evicted;
    logic [IdxOutWidth-1:0] line_index;
    logic [DataWidth-1:0]   read_data;
  } lookup_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgWidth-1:0] cfg_wdata;

  dmc_req_if req_if ();
  dmc_rsp_if rsp_if ();

  direct_mapped_cache_lookup dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  logic                 line_valid_q [LineCount];
  logic [AddrWidth-1:0] line_addr_q  [LineCount];
  logic [DataWidth-1:0] line_data_q  [LineCount];
  logic [CfgWidth-1:0]  lines_in_use;
  lookup_t              pending_lookups [$];
  logic [AddrWidth-1:0] hot_addrs [16];
  int unsigned          errors;
  int unsigned          cycle_count;
  bit                   sender_gaps;
  bit                   sink_gaps;
  int unsigned          sink_hold_off;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int unsigned used_lines();
    int unsigned used;
    used = lines_in_use;
    if (used == 0) used = 1;
    if (used > LineCount) used = LineCount;
    return used;
  endfunction

  function automatic lookup_t predict_lookup(input logic [AddrWidth-1:0] addr,
                                             input logic [DataWidth-1:0] word);
    int unsigned idx;
    lookup_t r;
    idx = addr % used_lines();
    r.hit = line_valid_q[idx] && (line_addr_q[idx] == addr);
    r.evicted = 1'b0;
    if (!r.hit) begin
      r.evicted = line_valid_q[idx];
      line_valid_q[idx] = 1'b1;
      line_addr_q[idx] = addr;
      line_data_q[idx] = word;
    end
    r.line_index = idx[IdxOutWidth-1:0];
    r.read_data = line_data_q[idx];
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [DataWidth-1:0] got,
                                 input logic [DataWidth-1:0] want);
    if (errors < PrintLimit) begin
      $display("mismatch on %s at cycle %0d: got %0h, want %0h", field, cycle_count, got, want);
    end
    errors++;
  endtask

  task automatic check_result();
    lookup_t want;
    if (pending_lookups.size() == 0) begin
      report_mismatch("response without request", '0, '0);
      return;
    end
    want = pending_lookups.pop_front();
    if (rsp_if.hit !== want.hit) begin
      report_mismatch("hit", DataWidth'(rsp_if.hit), DataWidth'(want.hit));
    end
    if (rsp_if.evicted !== want.evicted) begin
      report_mismatch("evicted", DataWidth'(rsp_if.evicted), DataWidth'(want.evicted));
    end
    if (rsp_if.line_index !== want.line_index) begin
      report_mismatch("line_index", DataWidth'(rsp_if.line_index),
                      DataWidth'(want.line_index));
    end
    if (rsp_if.read_data !== want.read_data) begin
      report_mismatch("read_data", rsp_if.read_data, want.read_data);
    end
  endtask

  initial begin : result_sink
    int unsigned stall;
    rsp_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (sink_hold_off > 0) begin
        stall = sink_hold_off;
        sink_hold_off = 0;
      end else begin
        stall = sink_gaps ? $urandom_range(0, MaxGap) : 0;
      end
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (rsp_if.valid !== 1'b1);
      check_result();
      @(negedge clk);
    end
  end

  task automatic send_request(input logic [AddrWidth-1:0] addr,
                              input logic [DataWidth-1:0] word);
    int unsigned gap;
    gap = sender_gaps ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.address <= addr;
    req_if.memory_word <= word;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    pending_lookups.push_back(predict_lookup(addr, word));
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    req_if.valid <= 1'b0;
    while (pending_lookups.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_lines(input logic [CfgWidth-1:0] value);
    wait_for_drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    lines_in_use = value;
  endtask

  task automatic test_cold_and_hit();
    send_request(16'h0000, 31'h7FFF_FFFF);
    send_request(16'h0000, 31'h0000_0000);
    send_request(16'hFFFF, 31'h0000_0000);
    send_request(16'hFFFF, 31'h5555_5555);
    send_request(16'h0100, 31'h2AAA_AAAA);
    send_request(16'h0000, 31'h1234_5678);
    send_request(16'hAAAA, 31'h0F0F_0F0F);
    send_request(16'h5555, 31'h70F0_F0F0);
  endtask

  task automatic test_line_count_limits();
    // zero lines acts as one line
    write_lines(9'd0);
    send_request(16'hFFFF, 31'h0000_0001);
    send_request(16'h1234, 31'h4000_0000);
    // counts above the line total saturate
    write_lines(9'h1FF);
    send_request(16'h01FF, 31'h3333_3333);
    write_lines(9'd1);
    send_request(16'h1234, 31'h0000_0000);
    // non power of two count
    write_lines(9'd255);
    send_request(16'hFFFF, 31'h6666_6666);
    send_request(16'h00FE, 31'h0ABC_DEF0);
    // lines keep contents across a count change
    write_lines(9'd256);
    send_request(16'd300, 31'h1357_9BDF);
    write_lines(9'd100);
    send_request(16'd300, 31'h2468_ACE0);
    write_lines(9'd256);
    send_request(16'd300, 31'h7FFF_0000);
  endtask

  task automatic test_backpressure();
    sender_gaps = 1'b0;
    sink_hold_off = 300;
    for (int i = 0; i < 12; i++) begin
      send_request(16'($urandom), 31'($urandom));
    end
    sender_gaps = 1'b1;
    wait_for_drain();
    // back to back with no stalls on either side
    sender_gaps = 1'b0;
    sink_gaps = 1'b0;
    for (int i = 0; i < 60; i++) begin
      send_request(16'($urandom_range(0, 511)), 31'($urandom));
    end
    sender_gaps = 1'b1;
    sink_gaps = 1'b1;
    wait_for_drain();
  endtask

  task automatic test_random_traffic(input int unsigned count);
    logic [CfgWidth-1:0]  setting;
    logic [AddrWidth-1:0] addr;
    int unsigned          per_phase;
    for (int i = 0; i < 16; i++) hot_addrs[i] = 16'($urandom);
    per_phase = count / 8;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       setting = 9'd256;
        1:       setting = 9'd1;
        2:       setting = 9'h1FF;
        3:       setting = 9'd0;
        4:       setting = 9'd255;
        5:       setting = 9'd7;
        default: setting = 9'($urandom);
      endcase
      write_lines(setting);
      for (int n = 0; n < per_phase; n++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: addr = hot_addrs[$urandom_range(0, 15)];
          4, 5: addr = hot_addrs[$urandom_range(0, 15)] +
                       16'(used_lines() * $urandom_range(1, 3));
          default: begin
            addr = 16'($urandom);
            hot_addrs[$urandom_range(0, 15)] = addr;
          end
        endcase
        send_request(addr, 31'($urandom));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_if.valid = 1'b0;
    req_if.address = '0;
    req_if.memory_word = '0;
    errors = 0;
    cycle_count = 0;
    sender_gaps = 1'b1;
    sink_gaps = 1'b1;
    sink_hold_off = 0;
    lines_in_use = CfgReset;
    for (int i = 0; i < LineCount; i++) begin
      line_valid_q[i] = 1'b0;
      line_addr_q[i] = '0;
      line_data_q[i] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_cold_and_hit();
    test_line_count_limits();
    test_backpressure();
    test_random_traffic(1000);

    wait_for_drain();
    repeat (40) @(negedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/dmc_pkg.sv
src/dmc_req_if.sv
src/dmc_rsp_if.sv
src/direct_mapped_cache_lookup.sv
tb/sv/tb.sv
